### rtl/uer_pkg.sv
`timescale 1ns / 1ps

package uer_pkg;

    localparam int COUNT_WIDTH_DEFAULT  = 16;
    localparam int TICKS_PER_CM_DEFAULT = 58;

    localparam int TRIG_W   = 8;
    localparam int TICKS_W  = 16;
    localparam int DIST_W   = 11;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RESET = 8'd10;
    localparam logic [TICKS_W-1:0] TIMEOUT_TICKS_RESET = 16'd30000;
    localparam logic [DIST_W-1:0]  TIMEOUT_DISTANCE    = 11'd999;
    localparam logic [DIST_W-1:0]  DIST_MAX            = 11'd2047;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'd1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2,
        PH_MEAS = 2'd3
    } phase_t;

    typedef struct packed {
        logic clear;
        logic load_one;
        logic incr;
    } cnt_ctrl_t;

    typedef struct packed {
        logic              busy_res;
        logic              timed_out;
        logic [DIST_W-1:0] distance_cm;
        logic              done_res;
        logic              trigger_out;
    } result_t;

endpackage

### rtl/ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// s_axis    in         s_axis_tvalid/tready        tdata[0] start_req, [1] echo
// m_axis    out        m_axis_tvalid/tready        tdata[0] trigger_out, [1] done_res,
//                                                  [12:2] distance_cm, [13] timed_out,
//                                                  [14] busy_res
// cfg       in         cfg_we                      cfg_index, cfg_data
//
// One transfer in gives one transfer out, through the input register and then the result register.
// An input register and a result register hold one item each, so a transfer
// can be taken in every cycle unless both are full and the output stalls;
// the measurement state updates as an item moves into the result register.
// A stalled output holds both stages. Reset returns the block to idle with
// the trigger and timeout registers at their defaults and no result pending.

module ultrasonic_echo_ranger #(
    parameter int COUNT_WIDTH  = uer_pkg::COUNT_WIDTH_DEFAULT,
    parameter int TICKS_PER_CM = uer_pkg::TICKS_PER_CM_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [0] start_req, [1] echo, upper bits zero
    input  logic [uer_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] trigger_out, [1] done_res, [12:2] distance_cm, [13] timed_out, [14] busy_res
    output logic [uer_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                             cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [uer_pkg::CFG_W-1:0]        cfg_data
);

    logic                          in_valid_reg, in_valid_next;
    logic                          start_reg, echo_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [uer_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [uer_pkg::TRIG_W-1:0]    trigger_ticks_reg;
    logic [uer_pkg::TICKS_W-1:0]   timeout_ticks_reg;
    logic                          advance;
    logic                          step;
    logic                          in_xfer;
    uer_pkg::cnt_ctrl_t            cnt_ctrl;
    uer_pkg::result_t              result;
    logic [uer_pkg::DIST_W-1:0]    quot;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign step          = in_valid_reg && advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            trigger_ticks_reg <= uer_pkg::TRIGGER_TICKS_RESET;
            timeout_ticks_reg <= uer_pkg::TIMEOUT_TICKS_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    uer_pkg::CFG_TRIGGER_TICKS:
                        trigger_ticks_reg <= cfg_data[uer_pkg::TRIG_W-1:0];
                    uer_pkg::CFG_TIMEOUT_TICKS:
                        timeout_ticks_reg <= cfg_data[uer_pkg::TICKS_W-1:0];
                    default:
                        trigger_ticks_reg <= trigger_ticks_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            start_reg <= s_axis_tdata[0];
            echo_reg  <= s_axis_tdata[1];
        end
        if (step)
        begin
            out_data_reg <= {1'b0, result};
        end
    end

    uer_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .start_req     (start_reg),
        .echo          (echo_reg),
        .trigger_ticks (trigger_ticks_reg),
        .timeout_ticks (timeout_ticks_reg),
        .quot          (quot),
        .cnt_ctrl      (cnt_ctrl),
        .result        (result)
    );

    uer_pulse_count #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .TICKS_PER_CM (TICKS_PER_CM)
    ) u_pulse_count (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (cnt_ctrl),
        .quot  (quot)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_out_timeout_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[13]) |-> (m_axis_tdata[12:2] == uer_pkg::TIMEOUT_DISTANCE))
        else $error("timed-out result without the timeout distance");

    a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("processed item did not reach the result register");

endmodule

### rtl/uer_pulse_count.sv
`timescale 1ns / 1ps

module uer_pulse_count #(
    parameter int COUNT_WIDTH  = uer_pkg::COUNT_WIDTH_DEFAULT,
    parameter int TICKS_PER_CM = uer_pkg::TICKS_PER_CM_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  uer_pkg::cnt_ctrl_t          ctrl,
    output logic [uer_pkg::DIST_W-1:0]  quot
);

    localparam int REM_W = $clog2(TICKS_PER_CM + 1);
    localparam logic [REM_W-1:0] REM_LAST = REM_W'(TICKS_PER_CM);

    // The width counter is kept together with its quotient and remainder by
    // the tick constant, so the distance is ready without a divider.
    logic [COUNT_WIDTH-1:0]     width_reg, width_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [uer_pkg::DIST_W-1:0] quot_reg, quot_next;

    always_comb
    begin
        logic [COUNT_WIDTH-1:0]     w_base;
        logic [REM_W-1:0]           r_base;
        logic [REM_W-1:0]           r_inc;
        logic [uer_pkg::DIST_W-1:0] q_base;

        w_base = ctrl.load_one ? '0 : width_reg;
        r_base = ctrl.load_one ? '0 : rem_reg;
        q_base = ctrl.load_one ? '0 : quot_reg;
        r_inc  = r_base + REM_W'(1);

        width_next = width_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;

        if (ctrl.clear)
        begin
            width_next = '0;
            rem_next   = '0;
            quot_next  = '0;
        end
        else if (ctrl.load_one || ctrl.incr)
        begin
            if (&w_base)
            begin
                width_next = '0;
                rem_next   = '0;
                quot_next  = '0;
            end
            else
            begin
                width_next = w_base + COUNT_WIDTH'(1);
                if (r_inc == REM_LAST)
                begin
                    rem_next  = '0;
                    quot_next = (q_base == uer_pkg::DIST_MAX) ? q_base
                                                               : q_base + 1'b1;
                end
                else
                begin
                    rem_next  = r_inc;
                    quot_next = q_base;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= '0;
            rem_reg   <= '0;
            quot_reg  <= '0;
        end
        else
        begin
            width_reg <= width_next;
            rem_reg   <= rem_next;
            quot_reg  <= quot_next;
        end
    end

    assign quot = quot_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < REM_LAST)
        else $error("remainder reached the tick constant");

endmodule

### rtl/uer_ctrl.sv
`timescale 1ns / 1ps

module uer_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          start_req,
    input  logic                          echo,
    input  logic [uer_pkg::TRIG_W-1:0]    trigger_ticks,
    input  logic [uer_pkg::TICKS_W-1:0]   timeout_ticks,
    input  logic [uer_pkg::DIST_W-1:0]    quot,
    output uer_pkg::cnt_ctrl_t            cnt_ctrl,
    output uer_pkg::result_t              result
);

    uer_pkg::phase_t              phase_reg, phase_next;
    logic [uer_pkg::TICKS_W-1:0]  ticks_reg, ticks_next;
    logic [uer_pkg::DIST_W-1:0]   dist_reg, dist_next;
    logic                         tmo_reg, tmo_next;
    logic                         launch;
    uer_pkg::phase_t              eff_phase;
    logic [uer_pkg::TICKS_W-1:0]  eff_ticks;

    assign launch    = (phase_reg == uer_pkg::PH_IDLE) && start_req;
    assign eff_phase = launch ? uer_pkg::PH_TRIG : phase_reg;
    assign eff_ticks = launch ? '0 : ticks_reg;

    // Next-state logic.
    always_comb
    begin
        logic [uer_pkg::TRIG_W-1:0]  t8;
        logic [uer_pkg::TICKS_W-1:0] t16;
        logic                        ended;

        t8         = eff_ticks[uer_pkg::TRIG_W-1:0] + 1'b1;
        t16        = eff_ticks + 1'b1;
        ended      = 1'b0;
        phase_next = eff_phase;
        ticks_next = eff_ticks;
        dist_next  = dist_reg;
        tmo_next   = tmo_reg;

        unique case (eff_phase)
            uer_pkg::PH_IDLE:
            begin
                ticks_next = eff_ticks;
            end
            uer_pkg::PH_TRIG:
            begin
                if (t8 == trigger_ticks)
                begin
                    phase_next = uer_pkg::PH_WAIT;
                    ticks_next = '0;
                end
                else
                begin
                    ticks_next = {{(uer_pkg::TICKS_W-uer_pkg::TRIG_W){1'b0}}, t8};
                end
            end
            uer_pkg::PH_WAIT, uer_pkg::PH_MEAS:
            begin
                if (eff_phase == uer_pkg::PH_WAIT)
                begin
                    if (echo)
                    begin
                        phase_next = uer_pkg::PH_MEAS;
                    end
                end
                else if (!echo)
                begin
                    dist_next  = quot;
                    tmo_next   = 1'b0;
                    phase_next = uer_pkg::PH_IDLE;
                    ticks_next = '0;
                    ended      = 1'b1;
                end
                if (!ended)
                begin
                    if (t16 == timeout_ticks)
                    begin
                        dist_next  = uer_pkg::TIMEOUT_DISTANCE;
                        tmo_next   = 1'b1;
                        phase_next = uer_pkg::PH_IDLE;
                        ticks_next = '0;
                    end
                    else
                    begin
                        ticks_next = t16;
                    end
                end
            end
            default:
            begin
                phase_next = uer_pkg::PH_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        cnt_ctrl.clear    = step && launch;
        cnt_ctrl.load_one = step && (eff_phase == uer_pkg::PH_WAIT) && echo;
        cnt_ctrl.incr     = step && (eff_phase == uer_pkg::PH_MEAS) && echo;

        result.trigger_out = (eff_phase == uer_pkg::PH_TRIG);
        result.done_res    = (eff_phase == uer_pkg::PH_WAIT || eff_phase == uer_pkg::PH_MEAS)
                             && (phase_next == uer_pkg::PH_IDLE);
        result.distance_cm = dist_next;
        result.timed_out   = tmo_next;
        result.busy_res    = (phase_next != uer_pkg::PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= uer_pkg::PH_IDLE;
            ticks_reg <= '0;
            dist_reg  <= '0;
            tmo_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            ticks_reg <= ticks_next;
            dist_reg  <= dist_next;
            tmo_reg   <= tmo_next;
        end
    end

    a_idle_ticks_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == uer_pkg::PH_IDLE) |-> (ticks_reg == '0))
        else $error("tick counter not cleared while idle");

    a_trig_ticks_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == uer_pkg::PH_TRIG)
        |-> (ticks_reg[uer_pkg::TICKS_W-1:uer_pkg::TRIG_W] == '0))
        else $error("trigger count exceeded its width");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.done_res) |-> !result.busy_res)
        else $error("finished measurement still reported busy");

    a_timeout_dist: assert property (@(posedge clk) disable iff (!rst_n)
        tmo_reg |-> (dist_reg == uer_pkg::TIMEOUT_DISTANCE))
        else $error("timeout flag held with a measured distance");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import uer_pkg::*;

    class range_tracker;
        logic [TRIG_W-1:0]              trig_len;
        logic [TICKS_W-1:0]             give_up;
        phase_t                         phase;
        logic [TICKS_W-1:0]             phase_ticks;
        logic [COUNT_WIDTH_DEFAULT-1:0] pulse_ticks;
        logic [DIST_W-1:0]              held_dist;
        logic                           tmo;
        result_t                        expected_q[$];
        int                             errors;
        int                             ranged;
        int                             timeouts;

        function new();
            trig_len    = TRIGGER_TICKS_RESET;
            give_up     = TIMEOUT_TICKS_RESET;
            phase       = PH_IDLE;
            phase_ticks = '0;
            pulse_ticks = '0;
            held_dist   = '0;
            tmo         = 1'b0;
            errors      = 0;
            ranged      = 0;
            timeouts    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == CFG_TRIGGER_TICKS)
            begin
                trig_len = value[TRIG_W-1:0];
            end
            else if (idx == CFG_TIMEOUT_TICKS)
            begin
                give_up = value;
            end
        endfunction

        function void end_measurement(logic [DIST_W-1:0] d, logic t);
            held_dist   = d;
            tmo         = t;
            phase       = PH_IDLE;
            phase_ticks = '0;
        endfunction

        function void note_tick(logic start, logic echo_lvl);
            result_t           r;
            logic              ended;
            logic [TRIG_W-1:0] trig_count;
            logic [31:0]       quotient;
            r     = '0;
            ended = 1'b0;
            if (phase == PH_IDLE && start)
            begin
                phase       = PH_TRIG;
                phase_ticks = '0;
                pulse_ticks = '0;
            end
            if (phase == PH_TRIG)
            begin
                r.trigger_out = 1'b1;
                trig_count    = phase_ticks[TRIG_W-1:0] + 1'b1;
                phase_ticks   = TICKS_W'(trig_count);
                if (trig_count == trig_len)
                begin
                    phase       = PH_WAIT;
                    phase_ticks = '0;
                end
            end
            else if (phase != PH_IDLE)
            begin
                if (phase == PH_WAIT)
                begin
                    if (echo_lvl)
                    begin
                        phase       = PH_MEAS;
                        pulse_ticks = COUNT_WIDTH_DEFAULT'(1);
                    end
                end
                else if (!echo_lvl)
                begin
                    quotient = pulse_ticks / TICKS_PER_CM_DEFAULT;
                    if (quotient > DIST_MAX)
                    begin
                        quotient = 32'(DIST_MAX);
                    end
                    end_measurement(quotient[DIST_W-1:0], 1'b0);
                    r.done_res = 1'b1;
                    ended      = 1'b1;
                    ranged++;
                end
                else
                begin
                    pulse_ticks = pulse_ticks + 1'b1;
                end
                if (!ended)
                begin
                    phase_ticks = phase_ticks + 1'b1;
                    if (phase_ticks == give_up)
                    begin
                        end_measurement(TIMEOUT_DISTANCE, 1'b1);
                        r.done_res = 1'b1;
                        timeouts++;
                    end
                end
            end
            r.distance_cm = held_dist;
            r.timed_out   = tmo;
            r.busy_res    = (phase != PH_IDLE);
            expected_q.push_back(r);
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_reading(logic [OUT_DATA_W-1:0] data);
            result_t got;
            result_t want;
            got = data[$bits(result_t)-1:0];
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result transfer with none expected, expected nothing, actual %h",
                         $time, data);
                return;
            end
            want = expected_q.pop_front();
            compare_field("trigger_out", want.trigger_out, got.trigger_out);
            compare_field("done_res", want.done_res, got.done_res);
            compare_field("distance_cm", want.distance_cm, got.distance_cm);
            compare_field("timed_out", want.timed_out, got.timed_out);
            compare_field("busy_res", want.busy_res, got.busy_res);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    int           send_idle_pct;
    int           stall_pct;
    int           hold_left;
    bit           hold_request;
    int           ticks_sent;
    range_tracker ranger;

    ultrasonic_echo_ranger DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        m_axis_tready = 1'b0;
        hold_left     = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                ranger.check_reading(m_axis_tdata);
            end
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = 150;
            end
            if (hold_left > 0)
            begin
                m_axis_tready = 1'b0;
                hold_left--;
            end
            else
            begin
                m_axis_tready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic logic coin();
        return 1'($urandom_range(1));
    endfunction

    task automatic send_tick(input logic start, input logic echo_lvl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {{(IN_DATA_W-2){1'b0}}, echo_lvl, start};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        ranger.note_tick(start, echo_lvl);
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (ranger.expected_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        settle();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        ranger.write_reg(idx, value);
    endtask

    // A noisy measurement throws random requests and echo levels at the trigger
    // and random requests at the wait and the pulse.
    task automatic measure(input int gap, input int pulse, input bit noisy);
        int trig_span;
        trig_span = (ranger.trig_len == 0) ? 256 : ranger.trig_len;
        send_tick(1'b1, noisy ? coin() : 1'b0);
        for (int i = 1; i < trig_span; i++)
        begin
            send_tick(noisy ? coin() : 1'b0, noisy ? coin() : 1'b0);
        end
        repeat (gap) send_tick(noisy ? coin() : 1'b0, 1'b0);
        repeat (pulse) send_tick(noisy ? coin() : 1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
    endtask

    task automatic random_phase(input int idle_pct, input int stall, input bit squeeze);
        int phase_start;
        int tmo;
        settle();
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        tmo           = $urandom_range(40, 150);
        set_reg(CFG_TRIGGER_TICKS, CFG_W'($urandom_range(1, 6)));
        set_reg(CFG_TIMEOUT_TICKS, CFG_W'(tmo));
        if (squeeze)
        begin
            hold_request = 1'b1;
        end
        phase_start = ticks_sent;
        while (ticks_sent - phase_start < 40)
        begin
            case ($urandom_range(9))
                0: repeat ($urandom_range(1, 6)) send_tick(coin(), coin());
                1: measure($urandom_range(0, 3), 0, 1'b1);
                2: measure($urandom_range(tmo - 10, tmo + 5), $urandom_range(0, 20), 1'b1);
                default: measure($urandom_range(0, 8), $urandom_range(0, 130), coin());
            endcase
        end
    endtask

    initial
    begin
        ranger        = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_TRIGGER_TICKS;
        cfg_data      = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 1'b0;
        ticks_sent    = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Echo activity without a request leaves the block idle.
        repeat (4) send_tick(1'b0, coin());
        measure(0, 60, 1'b1);
        set_reg(CFG_TRIGGER_TICKS, 1);
        set_reg(CFG_TIMEOUT_TICKS, 5);
        measure(10, 0, 1'b0);
        // The echo falls on the very tick the timeout expires.
        measure(2, 2, 1'b0);

        random_phase(0, 0, 1'b1);
        random_phase(68, 0, 1'b0);
        random_phase(0, 68, 1'b0);
        random_phase(13, 13, 1'b0);

        settle();
        repeat (8) @(negedge clk);
        $display("Run covered %0d tick transfers with %0d echo measurements and %0d timeouts.",
                 ticks_sent, ranger.ranged, ranger.timeouts);
        $display("Trigger lengths 1 to 10, timeouts 5 to 30000, four flow mixes, one long hold.");
        if (ranger.errors == 0 && ranger.expected_q.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
